// ===== rtl/deq_pkg.sv =====
// Shared types and constants of the double-ended queue unit.
package deq_pkg;

  // Default number of ring slots.
  localparam int unsigned DefDepth = 64;

  // Field widths of the stream payloads.
  localparam int unsigned CmdW  = 3;
  localparam int unsigned KindW = 3;
  localparam int unsigned DataW = 32;

  // Commands carried on the input side.
  typedef enum logic [CmdW-1:0] {
    CmdPushFront = 3'd0,
    CmdPushRear  = 3'd1,
    CmdPopFront  = 3'd2,
    CmdPopRear   = 3'd3,
    CmdList      = 3'd4
  } cmd_e;

  // Result kinds carried on the output side.
  typedef enum logic [KindW-1:0] {
    KindAck   = 3'd0,
    KindUnder = 3'd1,
    KindOver  = 3'd2,
    KindElem  = 3'd3,
    KindEmpty = 3'd4
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StPop  = 2'd1,
    StList = 2'd2
  } state_e;

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
// Double-ended queue of 32-bit values held in a ring memory, with stream ports.
//
// Input channel (s_axis): tuser carries the command (push front, push rear,
// pop front, pop rear, list) and tdata the value to push. Output channel
// (m_axis): tuser carries the result kind, tdata the popped or listed value
// and tlast marks the final result of a command.
//
// Pushes write the ring memory in the cycle of the transfer and their result
// appears in the following cycle; a push can be taken every cycle while the
// receiver takes the results. A pop that finds data reads the memory, whose
// read port is registered, and its result passes from the read data register
// to the output register. A list issues one memory read per element and
// streams the elements front to rear, one per cycle while the receiver takes
// them. Failed pushes and pops and an empty listing answer in the next cycle.
//
// One output register separates the two sides: a new command is taken while a
// finished result still waits, as long as the receiver takes it in that cycle.
// When the receiver stalls, the result holds and listing pauses.
// Reset empties the queue; the memory itself is not cleared, since only slots
// written by a push are ever read.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [31:0] value
  input  logic [CmdW-1:0]  s_axis_tuser,   // [2:0] cmd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // [31:0] value_res
  output logic [KindW-1:0] m_axis_tuser,   // [2:0] kind
  output logic             m_axis_tlast
);

  // Ring index, count and sum widths.
  localparam int unsigned AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // Bring a position in [0, 2*DEPTH) back into the ring.
  function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] pos);
    logic [SW-1:0] res;
    res = (pos >= DepthS) ? (pos - DepthS) : pos;
    return res[AW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;

  logic             m_valid_q, m_valid_d;
  logic [DataW-1:0] m_data_q, m_data_d;
  logic [KindW-1:0] m_kind_q, m_kind_d;
  logic             m_last_q, m_last_d;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rd_data_q;
  logic             mem_we, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;

  logic             out_free, in_xfer, out_load;
  logic             is_empty, is_full, list_end;
  cmd_e             cmd;
  logic [SW-1:0]    head_x, count_x, idx_x;

  assign out_free = !m_valid_q || m_axis_tready;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q >= DepthC);
  assign cmd      = cmd_e'(s_axis_tuser);
  assign head_x   = SW'(head_q);
  assign count_x  = SW'(count_q);
  assign idx_x    = SW'(idx_q);
  assign list_end = ((idx_x + SW'(1)) == count_x);

  // Next-state logic of the controller.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer && !is_empty) begin
          if (cmd == CmdPopFront || cmd == CmdPopRear) begin
            state_d = StPop;
          end else if (cmd == CmdList) begin
            state_d = StList;
          end
        end
      end
      StPop: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      StList: begin
        if (out_free && list_end) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath control: memory accesses, queue pointers and result loading.
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    wr_addr       = head_q;
    rd_en         = 1'b0;
    rd_addr       = head_q;
    head_d        = head_q;
    count_d       = count_q;
    idx_d         = idx_q;
    out_load      = 1'b0;
    m_data_d      = '0;
    m_kind_d      = KindAck;
    m_last_d      = 1'b1;
    case (state_q)
      StIdle: begin
        s_axis_tready = out_free;
        if (in_xfer) begin
          case (cmd)
            CmdPushFront, CmdPushRear: begin
              out_load = 1'b1;
              if (is_full) begin
                m_kind_d = KindOver;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (cmd == CmdPushFront) begin
                  wr_addr = ring_wrap(head_x + DepthS - SW'(1));
                  head_d  = wr_addr;
                end else begin
                  wr_addr = ring_wrap(head_x + count_x);
                end
              end
            end
            CmdPopFront, CmdPopRear: begin
              if (is_empty) begin
                out_load = 1'b1;
                m_kind_d = KindUnder;
              end else begin
                rd_en   = 1'b1;
                count_d = count_q - CW'(1);
                if (cmd == CmdPopFront) begin
                  rd_addr = head_q;
                  head_d  = ring_wrap(head_x + SW'(1));
                end else begin
                  rd_addr = ring_wrap(head_x + count_x - SW'(1));
                end
              end
            end
            CmdList: begin
              if (is_empty) begin
                out_load = 1'b1;
                m_kind_d = KindEmpty;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                idx_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      StPop: begin
        if (out_free) begin
          out_load = 1'b1;
          m_data_d = rd_data_q;
        end
      end
      StList: begin
        if (out_free) begin
          out_load = 1'b1;
          m_kind_d = KindElem;
          m_data_d = rd_data_q;
          m_last_d = list_end;
          if (!list_end) begin
            rd_en   = 1'b1;
            rd_addr = ring_wrap(head_x + idx_x + SW'(1));
            idx_d   = idx_q + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
      m_kind_q <= m_kind_d;
      m_last_q <= m_last_d;
    end
  end

  // Ring memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  // The element count never exceeds the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthC)
    else $error("Element count exceeds ring size.");

  // A pop result is only pending with the output register free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StPop) |-> !m_valid_q)
    else $error("Pop result pending while output register is occupied.");

  // Listing never runs past the number of held elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StList) |-> (idx_x < count_x))
    else $error("List index beyond element count.");

  // The queue contents stay unchanged while a list is streamed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StList) |=> ($stable(count_q) && $stable(head_q)))
    else $error("Queue changed during a list.");

  // A pop that leaves the idle state always produces a result with the read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StPop) |=> (m_valid_q && m_last_q))
    else $error("Pop finished without a result transfer pending.");

endmodule
